FILE: rtl/url_query_percent_decoder_macros.svh
// assertion macros shared by the decoder rtl
`ifndef URL_QUERY_PERCENT_DECODER_MACROS_SVH
`define URL_QUERY_PERCENT_DECODER_MACROS_SVH

// same-cycle implication, checked out of reset
`define UQPD_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("uqpd assertion failed");

// next-cycle implication, checked out of reset
`define UQPD_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("uqpd assertion failed");

`endif

FILE: rtl/uqpd_pkg.sv
// types, codes and helpers of the query percent decoder
package uqpd_pkg;

  typedef enum logic [5:0] {
    PH_PATH  = 6'b000001,
    PH_QUERY = 6'b000010,
    PH_ESC1  = 6'b000100,
    PH_ESC2  = 6'b001000,
    PH_FRAG  = 6'b010000,
    PH_FAIL  = 6'b100000
  } phase_t;

  typedef enum logic [2:0] {
    EV_KEY   = 3'd0,
    EV_VALUE = 3'd1,
    EV_PAIR  = 3'd2,
    EV_OK    = 3'd3,
    EV_FAIL  = 3'd4
  } ev_kind_t;

  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_HASH    = 8'h23;
  localparam logic [7:0] CH_QMARK   = 8'h3f;
  localparam logic [7:0] CH_AMP     = 8'h26;
  localparam logic [7:0] CH_EQUAL   = 8'h3d;
  localparam logic [7:0] CH_NUL     = 8'h00;

  localparam int unsigned MAX_EVENTS = 3;

  typedef struct packed {
    phase_t     phase;
    logic       in_value;
    logic [3:0] high_nibble;
    logic       pair_nonempty;
  } state_t;

  localparam state_t ST_RESET = '{
    phase: PH_PATH, in_value: 1'b0, high_nibble: 4'h0, pair_nonempty: 1'b0
  };

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] data;
  } event_t;

  typedef struct packed {
    logic [1:0]                  cnt;
    event_t [MAX_EVENTS-1:0]     ev;
  } ev_bundle_t;

  // {ok, nibble} for one ascii hex digit of either case
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'b0_0000;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

endpackage

FILE: rtl/uqpd_step.sv
// next state and result events for one request
module uqpd_step import uqpd_pkg::*; (
  input  state_t     st,
  input  logic [7:0] char_in,
  input  logic       char_valid,
  input  logic       string_end,
  output state_t     st_nxt,
  output ev_bundle_t bundle
);

  always_comb begin
    state_t     s;
    logic [1:0] n;
    logic [4:0] hex;
    ev_kind_t   byte_kind;
    logic       failed;
    s         = st;
    n         = 2'd0;
    bundle.ev = '0;
    hex       = hex_decode(char_in);
    byte_kind = st.in_value ? EV_VALUE : EV_KEY;
    failed    = 1'b0;

    if (char_valid) begin
      unique case (st.phase) inside
        PH_PATH: begin
          if (char_in == CH_QMARK) begin
            s.phase = PH_QUERY;
          end else if (char_in == CH_HASH) begin
            s.phase = PH_FRAG;
          end
        end
        PH_QUERY: begin
          if (char_in == CH_HASH) begin
            if (st.pair_nonempty) begin
              bundle.ev[n] = '{kind: EV_PAIR, data: 8'h00};
              n = n + 2'd1;
            end
            s.phase = PH_FRAG;
          end else if (char_in == CH_AMP) begin
            if (st.pair_nonempty) begin
              bundle.ev[n] = '{kind: EV_PAIR, data: 8'h00};
              n = n + 2'd1;
            end
            s.in_value      = 1'b0;
            s.pair_nonempty = 1'b0;
          end else begin
            s.pair_nonempty = 1'b1;
            if (char_in == CH_PERCENT) begin
              s.phase = PH_ESC1;
            end else if (char_in == CH_EQUAL && !st.in_value) begin
              s.in_value = 1'b1;
            end else if (char_in == CH_NUL) begin
              s.phase = PH_FAIL;
            end else begin
              bundle.ev[n] = '{kind: byte_kind, data: char_in};
              n = n + 2'd1;
            end
          end
        end
        PH_ESC1: begin
          if (!hex[4]) begin
            s.phase = PH_FAIL;
          end else begin
            s.high_nibble = hex[3:0];
            s.phase       = PH_ESC2;
          end
        end
        PH_ESC2: begin
          // %00 counts as a bad escape
          if (!hex[4] || {st.high_nibble, hex[3:0]} == CH_NUL) begin
            s.phase = PH_FAIL;
          end else begin
            bundle.ev[n] = '{kind: byte_kind, data: {st.high_nibble, hex[3:0]}};
            n = n + 2'd1;
            s.phase = PH_QUERY;
          end
        end
        PH_FRAG, PH_FAIL: begin
        end
        default: begin
        end
      endcase
    end

    if (string_end) begin
      failed = (s.phase == PH_ESC1) || (s.phase == PH_ESC2) || (s.phase == PH_FAIL);
      if (s.phase == PH_QUERY && s.pair_nonempty) begin
        bundle.ev[n] = '{kind: EV_PAIR, data: 8'h00};
        n = n + 2'd1;
      end
      bundle.ev[n] = '{kind: (failed ? EV_FAIL : EV_OK), data: 8'h00};
      n = n + 2'd1;
      s = ST_RESET;
    end

    st_nxt     = s;
    bundle.cnt = n;
  end

endmodule

FILE: rtl/uqpd_evbuf.sv
// result register holding the events of one request, drained one per cycle while out_stall is low
module uqpd_evbuf import uqpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  ev_bundle_t bundle,
  output logic       can_load,
  output logic       out_valid,
  input  logic       out_stall,
  output ev_kind_t   out_kind,
  output logic [7:0] out_data,
  output logic       out_last
);

  `include "url_query_percent_decoder_macros.svh"

  logic [1:0]   cnt_r, cnt_nxt;
  logic [1:0]   idx_r, idx_nxt;
  event_t [2:0] ev_r;
  logic         take;

  assign out_valid = (cnt_r != 2'd0);
  assign out_last  = out_valid && (idx_r == cnt_r - 2'd1);
  assign out_kind  = ev_r[idx_r].kind;
  assign out_data  = ev_r[idx_r].data;
  assign take      = out_valid && !out_stall;
  assign can_load  = !out_valid || (take && out_last);

  always_comb begin
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    if (load) begin
      cnt_nxt = bundle.cnt;
      idx_nxt = 2'd0;
    end else if (take) begin
      if (out_last) begin
        cnt_nxt = 2'd0;
        idx_nxt = 2'd0;
      end else begin
        idx_nxt = idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
      idx_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ev_r <= bundle.ev;
    end
  end

  `UQPD_ASSERT_IMP(a_idx_in_range, cnt_r != 2'd0, idx_r < cnt_r)
  `UQPD_ASSERT_IMP(a_load_only_free, load && out_valid, take && out_last)

endmodule

FILE: rtl/url_query_percent_decoder.sv
// top level of the location string query percent decoder
//
//   channel | direction | ports                                   | handshake
//   --------+-----------+-----------------------------------------+---------------
//   in      | input     | in_char_in, in_char_valid, in_string_end | in_valid/stall
//   out     | output    | out_event_kind, out_decoded_byte,       | out_valid/stall
//           |           | out_run_last                            |
//
// one request per cycle enters the input register while in_stall is low; the step
// logic then updates the parse state and loads zero to three events into the
// result register once that is free; the result register drains one event per
// cycle while out_stall is low, and a request waits in the input register until
// the result register is empty or hands out its last event
// rst_n is synchronous and returns the parser to the path phase
// out_stall backs up into in_stall through the result and input registers
module url_query_percent_decoder import uqpd_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_char_valid,
  input  logic       in_string_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_event_kind,
  output logic [7:0] out_decoded_byte,
  output logic       out_run_last
);

  `include "url_query_percent_decoder_macros.svh"

  // input register
  logic       hold_vld_r;
  logic [7:0] char_r;
  logic       cvalid_r;
  logic       end_r;

  // parse state
  state_t     state_r;
  state_t     state_nxt;

  ev_bundle_t bundle;
  logic       can_load;
  logic       advance;
  logic       in_take;
  ev_kind_t   kind;

  // the held request moves into the result register once it is free
  assign advance  = hold_vld_r && can_load;
  assign in_stall = hold_vld_r && !can_load;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_vld_r <= 1'b0;
    end else if (in_take) begin
      hold_vld_r <= 1'b1;
    end else if (advance) begin
      hold_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      char_r   <= in_char_in;
      cvalid_r <= in_char_valid;
      end_r    <= in_string_end;
    end
  end

  uqpd_step u_step (
    .st         (state_r),
    .char_in    (char_r),
    .char_valid (cvalid_r),
    .string_end (end_r),
    .st_nxt     (state_nxt),
    .bundle     (bundle)
  );

  // state advances exactly once per request, in request order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RESET;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  uqpd_evbuf u_evbuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .bundle    (bundle),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_kind  (kind),
    .out_data  (out_decoded_byte),
    .out_last  (out_run_last)
  );

  assign out_event_kind = kind;

  `UQPD_ASSERT_IMP(a_phase_onehot, 1'b1, $onehot(state_r.phase))
  `UQPD_ASSERT_IMP(a_stall_needs_hold, in_stall, hold_vld_r && out_valid)
  `UQPD_ASSERT_NXT(a_end_resets, advance && end_r, state_r == ST_RESET)

endmodule
